/* hdl/pscq_pkg.sv */
// Package for the per-source capped, timed batch queue.
// Holds the word types, codes, reset values and shared control structs.
// Used by pscq_dp, pscq_ctrl and the top level; depends on nothing.
package pscq_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_QUEUE_DEPTH = 128;
  localparam int DEF_MAX_BATCH   = 3;

  // Operation codes of an input word.
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_CHECKED   = 2'd1;
  localparam logic [1:0] OP_UNCHECKED = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_BATCH    = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;
  localparam logic [1:0] CFG_STEP     = 2'd3;

  // Register reset values.
  localparam logic [2:0]  RST_LIMIT    = 3'd3;
  localparam logic [1:0]  RST_BATCH    = 2'd3;
  localparam logic [31:0] RST_INTERVAL = 32'd5000;
  localparam logic [7:0]  RST_STEP     = 8'd5;

  // Division by three as a multiply by a rounded-up reciprocal and a shift.
  // Exact for every dividend up to 4096.
  localparam int RECIP_W    = 16;
  localparam int DIV3_RECIP = 21846;

  localparam int          STEP_W  = 8;
  localparam int          EST_W   = 15;
  localparam logic [31:0] EST_MAX = 32'd32767;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] source_id;
    logic [15:0] message_handle;
    logic [31:0] current_time;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [2:0]  source_count;
    logic [14:0] wait_estimate;
    logic [31:0] out_source;
    logic [15:0] out_message;
    logic        last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic append;
    logic scan;
    logic calc;
    logic reply;
    logic pop_start;
    logic pop_read;
    logic pop_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_checked;
    logic is_unchecked;
    logic is_tick;
    logic tick_go;
    logic scan_done;
    logic out_free;
    logic pop_last;
  } stat_t;

endpackage

/* hdl/pscq_dp.sv */
// Datapath of the batch queue: entry memory, pointers, configuration
// registers, the per-source scan, the wait estimate and the output register.
// Depends on pscq_pkg; driven by pscq_ctrl through cmd_t and stat_t.
module pscq_dp #(
  parameter int QUEUE_DEPTH = pscq_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_BATCH   = pscq_pkg::DEF_MAX_BATCH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  input  pscq_pkg::in_t    in_data_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output pscq_pkg::out_t   out_data_o,
  input  pscq_pkg::cmd_t   cmd_i,
  output pscq_pkg::stat_t  stat_o
);
  import pscq_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int BAT_W  = $clog2(MAX_BATCH + 1);
  localparam int MUL_W  = OCC_W + RECIP_W;
  localparam int PROD_W = OCC_W + STEP_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  // Configuration.
  logic [2:0]  limit_q;
  logic [1:0]  batch_q;
  logic [31:0] interval_q;
  logic [7:0]  step_q;

  // Queue state.
  logic [47:0]      mem_q [QUEUE_DEPTH];
  logic [47:0]      rd_data_q;
  logic [PTR_W-1:0] head_q, tail_q;
  logic [OCC_W-1:0] occ_q;
  logic [31:0]      last_time_q;

  // Work registers.
  in_t              item_q;
  logic [PTR_W-1:0] scan_pos_q;
  logic [OCC_W-1:0] issued_q, cmp_cnt_q;
  logic             rd_vld_q;
  logic [2:0]       count_q;
  logic [OCC_W-1:0] quot_q;
  logic [PROD_W-1:0] prod_q;
  logic [BAT_W-1:0] rem_q;

  out_t out_q;
  logic out_valid_q;

  logic [BAT_W-1:0] eff_batch;
  logic [BAT_W-1:0] pop_n;
  logic [MUL_W-1:0] div3_prod;
  logic [OCC_W-1:0] quot_d;
  logic [31:0]      prod_ext;
  logic [31:0]      elapsed;
  logic             full, scan_done, issue, compare, match, accept_ok, append_en;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  out_t             reply_w, bcast_w;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // Batch of zero acts as one; above MAX_BATCH it is clamped.
  always_comb begin
    if (batch_q == 2'd0) begin
      eff_batch = BAT_W'(1);
    end else if (int'(batch_q) > MAX_BATCH) begin
      eff_batch = BAT_W'(MAX_BATCH);
    end else begin
      eff_batch = BAT_W'(batch_q);
    end
  end

  assign div3_prod = MUL_W'(occ_q) * MUL_W'(DIV3_RECIP);

  always_comb begin
    if (int'(eff_batch) == 1) begin
      quot_d = occ_q;
    end else if (int'(eff_batch) == 2) begin
      quot_d = occ_q >> 1;
    end else begin
      quot_d = OCC_W'(div3_prod >> RECIP_W);
    end
  end

  assign pop_n = (int'(occ_q) < int'(eff_batch)) ? BAT_W'(occ_q) : eff_batch;

  assign full      = (occ_q == OCC_FULL);
  assign elapsed   = item_q.current_time - last_time_q;
  assign scan_done = (count_q >= limit_q) || (cmp_cnt_q == occ_q);
  assign issue     = cmd_i.scan && !scan_done && (issued_q != occ_q);
  assign compare   = cmd_i.scan && !scan_done && rd_vld_q;
  assign match     = (rd_data_q[47:16] == item_q.source_id);
  assign accept_ok = (count_q < limit_q) && !full;
  assign append_en = (cmd_i.reply && accept_ok) || (cmd_i.append && !full);

  assign rd_en   = issue || cmd_i.pop_read;
  assign rd_addr = cmd_i.pop_read ? head_q : scan_pos_q;

  assign prod_ext = 32'(prod_q);

  always_comb begin
    reply_w               = '0;
    reply_w.accepted      = accept_ok;
    if (accept_ok) begin
      reply_w.source_count  = count_q + 3'd1;
      reply_w.wait_estimate = (prod_ext > EST_MAX) ? EST_W'(EST_MAX) : EST_W'(prod_ext);
    end
    bcast_w             = '0;
    bcast_w.kind        = 1'b1;
    bcast_w.out_source  = rd_data_q[47:16];
    bcast_w.out_message = rd_data_q[15:0];
    bcast_w.last        = (int'(rem_q) == 1);
  end

  assign stat_o.is_checked   = (item_q.operation == OP_CHECKED);
  assign stat_o.is_unchecked = (item_q.operation == OP_UNCHECKED);
  assign stat_o.is_tick      = (item_q.operation == OP_TICK);
  assign stat_o.tick_go      = (elapsed >= interval_q) && (occ_q != '0);
  assign stat_o.scan_done    = scan_done;
  assign stat_o.out_free     = !out_valid_q || !out_stall_i;
  assign stat_o.pop_last     = (int'(rem_q) == 1);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (append_en) begin
      mem_q[tail_q] <= {item_q.source_id, item_q.message_handle};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
      quot_q <= quot_d;
    end
    if (cmd_i.calc) begin
      prod_q <= PROD_W'(quot_q) * PROD_W'(step_q);
    end
    if (cmd_i.reply) begin
      out_q <= reply_w;
    end else if (cmd_i.pop_load) begin
      out_q <= bcast_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= RST_LIMIT;
      batch_q     <= RST_BATCH;
      interval_q  <= RST_INTERVAL;
      step_q      <= RST_STEP;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      last_time_q <= '0;
      scan_pos_q  <= '0;
      issued_q    <= '0;
      cmp_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LIMIT:    limit_q    <= cfg_data_i[2:0];
          CFG_BATCH:    batch_q    <= cfg_data_i[1:0];
          CFG_INTERVAL: interval_q <= cfg_data_i;
          CFG_STEP:     step_q     <= cfg_data_i[7:0];
          default:      ;
        endcase
      end

      // The scan walks from the head; each entry is compared in the cycle after its read.
      if (cmd_i.accept) begin
        scan_pos_q <= head_q;
        issued_q   <= '0;
        cmp_cnt_q  <= '0;
        rd_vld_q   <= 1'b0;
        count_q    <= '0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= issue;
        if (issue) begin
          scan_pos_q <= next_ptr(scan_pos_q);
          issued_q   <= issued_q + 1'b1;
        end
        if (compare) begin
          cmp_cnt_q <= cmp_cnt_q + 1'b1;
          if (match) begin
            count_q <= count_q + 3'd1;
          end
        end
      end

      if (append_en) begin
        tail_q <= next_ptr(tail_q);
        occ_q  <= occ_q + 1'b1;
      end else if (cmd_i.pop_load) begin
        occ_q <= occ_q - 1'b1;
      end

      if (cmd_i.pop_start) begin
        rem_q <= pop_n;
      end else if (cmd_i.pop_load) begin
        rem_q  <= rem_q - 1'b1;
        head_q <= next_ptr(head_q);
        if (int'(rem_q) == 1) begin
          last_time_q <= item_q.current_time;
        end
      end

      if (cmd_i.reply || cmd_i.pop_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* hdl/pscq_ctrl.sv */
// Controller of the batch queue: a one-hot state machine that sequences
// dispatch, the per-source scan, the reply and the broadcast pops.
// Depends on pscq_pkg; talks to pscq_dp through cmd_t and stat_t.
module pscq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pscq_pkg::stat_t  stat_i,
  output pscq_pkg::cmd_t   cmd_o
);
  import pscq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_CALC     = 7'b0001000,
    S_REPLY    = 7'b0010000,
    S_POP_RD   = 7'b0100000,
    S_POP_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_checked) begin
          state_d = S_SCAN;
        end else if (stat_i.is_unchecked) begin
          cmd_o.append = 1'b1;
          state_d      = S_IDLE;
        end else if (stat_i.is_tick && stat_i.tick_go) begin
          cmd_o.pop_start = 1'b1;
          state_d         = S_POP_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_REPLY;
      end
      S_REPLY: begin
        if (stat_i.out_free) begin
          cmd_o.reply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_POP_RD: begin
        cmd_o.pop_read = 1'b1;
        state_d        = S_POP_OUT;
      end
      S_POP_OUT: begin
        // Read data stays put until the output register can take the word.
        if (stat_i.out_free) begin
          cmd_o.pop_load = 1'b1;
          state_d        = stat_i.pop_last ? S_IDLE : S_POP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/per_source_capped_timed_batch_queue_top.sv */
// Per-source capped, timed batch queue: a FIFO of (source id, handle)
// words with per-source admission and interval-gated batch broadcast.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one word at a
// time: a tick, a checked add or an unchecked add. Output channel
// (out_valid_o / out_stall_i / out_data_o) carries admission replies and
// broadcast entries; the last entry of a batch has last set. Configuration
// writes (cfg_valid_i / cfg_ready_o) are taken every cycle.
// Work per input word, paced by the single read port of the entry memory:
//   checked add   : a scan that reads one entry a cycle and stops early once
//                   the source limit is reached or every entry is compared,
//                   then the wait estimate and the reply;
//   unchecked add : one append;   tick : a read and an output load per entry.
// The input is stalled while a word is in progress. One output register
// decouples the sides: a stalled receiver holds the current result and the
// block waits at its next result until that register frees up.
// Reset empties the queue, zeroes the broadcast time stamp and restores the
// register defaults at once; there is no clearing pass.
module per_source_capped_timed_batch_queue_top #(
  parameter int QUEUE_DEPTH = pscq_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_BATCH   = pscq_pkg::DEF_MAX_BATCH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pscq_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pscq_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i
);
  import pscq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  pscq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pscq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BATCH   (MAX_BATCH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
